@@ rtl/q16_dense_layer_relu_defines.svh @@
// Assertion macros shared by the q16 dense layer RTL.
// Depends on nothing; users must provide clk and rst_n in scope.
`ifndef Q16_DENSE_LAYER_RELU_DEFINES_SVH
`define Q16_DENSE_LAYER_RELU_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define Q16DL_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define Q16DL_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define Q16DL_ASSERT(name, prop, msg)
`define Q16DL_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

@@ rtl/q16dl_pkg.sv @@
// Types and constants for the q16 dense layer block.
// Used by q16dl_mac and q16_dense_layer_relu; depends on nothing.
package q16dl_pkg;

    localparam logic [10:0] MAX_INPUTS  = 11'd1024;
    localparam logic [10:0] MAX_OUTPUTS = 11'd1024;
    localparam int          Q_SHIFT     = 16;

    localparam logic [1:0] REG_INPUT_COUNT  = 2'd0;
    localparam logic [1:0] REG_OUTPUT_COUNT = 2'd1;
    localparam logic [1:0] REG_RELU_ENABLE  = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_BIAS   = 2'd1,
        OP_WEIGHT = 2'd2
    } opcode_t;

    typedef struct packed {
        logic       valid;
        logic       is_bias;
        logic       emit;
        logic [9:0] index;
        logic       last;
    } mac_ctl_t;

    typedef struct packed {
        logic [31:0] value;
        logic [9:0]  index;
        logic        last;
    } mac_res_t;

endpackage

@@ rtl/q16dl_mac.sv @@
// Multiply and accumulate stages of the q16 dense layer.
// Depends on q16dl_pkg for the control and result structs.
module q16dl_mac (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  q16dl_pkg::mac_ctl_t ctl,
    input  logic [31:0]        weight,
    input  logic [31:0]        act,
    input  logic               relu_enable,
    output logic               res_valid,
    output q16dl_pkg::mac_res_t res
);
    import q16dl_pkg::*;

    mac_ctl_t           s2_ctl_reg;
    logic signed [63:0] prod_reg;
    logic [31:0]        s2_data_reg;
    logic [31:0]        acc_reg;
    logic [31:0]        acc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_ctl_reg <= '0;
            acc_reg    <= '0;
        end
        else if (adv)
        begin
            s2_ctl_reg <= ctl;
            if (s2_ctl_reg.valid)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg    <= $signed(weight) * $signed(act);
            s2_data_reg <= weight;
        end
    end

    always_comb
    begin
        if (s2_ctl_reg.is_bias)
        begin
            acc_next = s2_data_reg;
        end
        else
        begin
            acc_next = acc_reg + prod_reg[Q_SHIFT+31:Q_SHIFT];
        end
        res_valid = adv && s2_ctl_reg.valid && s2_ctl_reg.emit;
        res.value = (relu_enable && acc_next[31]) ? 32'd0 : acc_next;
        res.index = s2_ctl_reg.index;
        res.last  = s2_ctl_reg.last;
    end

endmodule

@@ rtl/q16_dense_layer_relu.sv @@
// Top level of the q16 dense layer with optional ReLU: sequencer, activation store,
// configuration registers and output skid stage. Depends on q16dl_pkg, q16dl_mac
// and q16_dense_layer_relu_defines.svh.
//
//   Channel  Kind          Payload
//   s_*      stream in     tuser: opcode; tdata: act_index, data_value
//   m_*      stream out    tdata: neuron_value, neuron_index; tlast: last_neuron
//   apb      config        input_count @0x0, output_count @0x4, relu_enable @0x8
//
// One item is taken per cycle while s_tready is high; a weight or bias transfer that
// completes a neuron reaches m_tvalid via s1_ctl_reg, s2_ctl_reg and the output
// register. The store read, the multiplier and the accumulator add each take one
// pipeline stage. A one-entry skid buffer feeding out_reg absorbs a stall; s_tready
// drops only while full. Reset clears control and the accumulator, not act_mem.
`include "q16_dense_layer_relu_defines.svh"

module q16_dense_layer_relu (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // act_index[9:0], data_value[41:10], zeros
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // neuron_value[31:0], neuron_index[41:32], zeros
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import q16dl_pkg::*;

    logic [31:0] act_mem [1024];

    logic [10:0] input_count_reg;
    logic [10:0] output_count_reg;
    logic        relu_enable_reg;

    logic [10:0] tap_reg;
    logic [10:0] tap_next;
    logic        open_reg;
    logic        open_next;
    logic [9:0]  nc_reg;
    logic [9:0]  nc_next;

    mac_ctl_t    s1_ctl_reg;
    mac_ctl_t    s1_ctl_next;
    logic [31:0] s1_data_reg;
    logic [31:0] rd_data_reg;

    logic        out_valid_reg;
    mac_res_t    out_reg;
    logic        skid_valid_reg;
    mac_res_t    skid_reg;

    logic        adv;
    logic        accept;
    logic        cfg_write;
    opcode_t     in_op;
    logic [9:0]  in_index;
    logic [31:0] in_data;
    logic [10:0] taps_needed;
    logic [10:0] neurons;
    logic [10:0] tap_inc;
    logic        last_flag;
    logic        res_valid;
    mac_res_t    res;
    logic        out_take;

    assign adv       = !skid_valid_reg;
    assign s_tready  = adv;
    assign accept    = s_tvalid && adv;
    assign in_op     = opcode_t'(s_tuser);
    assign in_index  = s_tdata[9:0];
    assign in_data   = s_tdata[41:10];
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign out_take  = out_valid_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_count_reg  <= 11'd1024;
            output_count_reg <= 11'd1024;
            relu_enable_reg  <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_INPUT_COUNT:  input_count_reg  <= pwdata[10:0];
                REG_OUTPUT_COUNT: output_count_reg <= pwdata[10:0];
                REG_RELU_ENABLE:  relu_enable_reg  <= pwdata[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_INPUT_COUNT:  prdata = {21'd0, input_count_reg};
            REG_OUTPUT_COUNT: prdata = {21'd0, output_count_reg};
            REG_RELU_ENABLE:  prdata = {31'd0, relu_enable_reg};
            default:          prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        taps_needed = (input_count_reg > MAX_INPUTS) ? MAX_INPUTS : input_count_reg;
        if (output_count_reg == 11'd0)
        begin
            neurons = 11'd1;
        end
        else if (output_count_reg > MAX_OUTPUTS)
        begin
            neurons = MAX_OUTPUTS;
        end
        else
        begin
            neurons = output_count_reg;
        end
        tap_inc   = tap_reg + 11'd1;
        last_flag = ({1'b0, nc_reg} + 11'd1) >= neurons;

        tap_next          = tap_reg;
        open_next         = open_reg;
        nc_next           = nc_reg;
        s1_ctl_next       = '0;
        s1_ctl_next.index = nc_reg;
        s1_ctl_next.last  = last_flag;

        if (accept)
        begin
            unique case (in_op)
                OP_BIAS:
                begin
                    s1_ctl_next.valid   = 1'b1;
                    s1_ctl_next.is_bias = 1'b1;
                    tap_next            = 11'd0;
                    open_next           = 1'b1;
                    if (taps_needed == 11'd0)
                    begin
                        s1_ctl_next.emit = 1'b1;
                        open_next        = 1'b0;
                        nc_next          = last_flag ? 10'd0 : 10'(nc_reg + 10'd1);
                    end
                end
                OP_WEIGHT:
                begin
                    if (open_reg)
                    begin
                        s1_ctl_next.valid = 1'b1;
                        tap_next          = tap_inc;
                        if (tap_inc >= taps_needed)
                        begin
                            s1_ctl_next.emit = 1'b1;
                            open_next        = 1'b0;
                            tap_next         = 11'd0;
                            nc_next          = last_flag ? 10'd0 : 10'(nc_reg + 10'd1);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg    <= '0;
            open_reg   <= 1'b0;
            nc_reg     <= '0;
            s1_ctl_reg <= '0;
        end
        else if (adv)
        begin
            tap_reg    <= tap_next;
            open_reg   <= open_next;
            nc_reg     <= nc_next;
            s1_ctl_reg <= s1_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_data_reg <= in_data;
            rd_data_reg <= act_mem[tap_reg[9:0]];
            if (in_op == OP_LOAD)
            begin
                act_mem[in_index] <= in_data;
            end
        end
    end

    q16dl_mac u_mac (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .ctl         (s1_ctl_reg),
        .weight      (s1_data_reg),
        .act         (rd_data_reg),
        .relu_enable (relu_enable_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= res_valid;
            end
        end
        else if (res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (res_valid)
            begin
                out_reg <= res;
            end
        end
        else if (res_valid)
        begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.index, out_reg.value};
    assign m_tlast  = out_reg.last;

    `Q16DL_ASSERT_ALWAYS(a_skid_needs_out, skid_valid_reg |-> out_valid_reg, "skid full while output empty")
    `Q16DL_ASSERT(a_skid_fill_on_stall, $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready), "skid filled without a stalled output")
    `Q16DL_ASSERT(a_idle_tap_zero, !open_reg |-> (tap_reg == 11'd0), "tap counter nonzero with no open neuron")
    `Q16DL_ASSERT(a_orphan_weight_dropped, (accept && (in_op == OP_WEIGHT) && !open_reg) |=> !s1_ctl_reg.valid, "weight without a neuron entered the pipeline")

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for q16_dense_layer_relu: loads activations, streams bias and
// weight transfers, and checks every neuron result against a Q16 dot-product predictor.
// Depends on q16dl_pkg and the q16_dense_layer_relu RTL.
module tb;

    import q16dl_pkg::*;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         CYCLE_LIMIT  = 600000;
    localparam int         N_DIR        = 31;
    localparam int         N_PHASES     = 8;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [9:0]  idx;
        logic [31:0] data;
    } layer_item_t;

    typedef struct {
        row_kind_t   kind;
        logic [1:0]  sel;
        logic [9:0]  idx;
        logic [31:0] data;
        bit          typed;
        mac_res_t    want;
    } dir_row_t;

    typedef struct {
        logic [10:0] inputs;
        logic [10:0] outputs;
        logic        relu;
        int          items;
        bit          hold;
    } layer_phase_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    q16_dense_layer_relu dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    logic [31:0] act_mem [1024];
    bit          act_written [1024];
    logic [31:0] acc_sum;
    int          taps_done;
    logic [9:0]  neuron_no;
    bit          neuron_busy;
    logic [10:0] cfg_inputs;
    logic [10:0] cfg_outputs;
    logic        cfg_relu;

    mac_res_t    pending_neurons [$];
    int          errors = 0;
    int          cycle_cnt = 0;
    int          hold_asked;
    int          hold_served = 0;
    int          hold_left = 0;
    int          rx_tick = 0;
    int          rx_mode = 0;
    int          burst_left;
    mac_res_t    want;

    dir_row_t     dir_tab [N_DIR];
    layer_phase_t phase_tab [N_PHASES];

    function automatic int tap_limit();
        return (cfg_inputs > MAX_INPUTS) ? int'(MAX_INPUTS) : int'(cfg_inputs);
    endfunction

    function automatic int layer_size();
        if (cfg_outputs == 11'd0)
            return 1;
        return (cfg_outputs > MAX_OUTPUTS) ? int'(MAX_OUTPUTS) : int'(cfg_outputs);
    endfunction

    function automatic bit predict_neuron(input logic [1:0] op, input logic [9:0] idx,
                                          input logic [31:0] data, output mac_res_t res);
        longint      prod;
        logic [63:0] scaled;
        bit          fire;
        fire = 1'b0;
        res = '0;
        case (op)
            OP_LOAD:
            begin
                act_mem[idx] = data;
                act_written[idx] = 1'b1;
            end
            OP_BIAS:
            begin
                acc_sum = data;
                taps_done = 0;
                neuron_busy = 1'b1;
                fire = (tap_limit() == 0);
            end
            OP_WEIGHT:
            begin
                if (neuron_busy)
                begin
                    prod = longint'($signed(data)) * longint'($signed(act_mem[taps_done & 1023]));
                    scaled = prod >>> Q_SHIFT;
                    acc_sum = acc_sum + scaled[31:0];
                    taps_done++;
                    fire = (taps_done >= tap_limit());
                end
            end
            default:
            begin
            end
        endcase
        if (fire)
        begin
            res.value = (cfg_relu && acc_sum[31]) ? 32'd0 : acc_sum;
            res.index = neuron_no;
            res.last = (int'(neuron_no) + 1 >= layer_size());
            neuron_no = res.last ? 10'd0 : neuron_no + 10'd1;
            neuron_busy = 1'b0;
            taps_done = 0;
        end
        return fire;
    endfunction

    function automatic logic [31:0] rand_q16();
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 3))
                    0: r = 32'h7fff_ffff;
                    1: r = 32'h8000_0000;
                    2: r = 32'h0000_0000;
                    default: r = 32'hffff_ffff;
                endcase
            end
            1, 2, 3: r = {{14{r[17]}}, r[17:0]};
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic layer_item_t next_layer_item();
        layer_item_t it;
        int          span;
        int          target;
        it.op = OP_BIAS;
        it.idx = 10'($urandom_range(0, 1023));
        it.data = rand_q16();
        if (!neuron_busy)
        begin
            case ($urandom_range(0, 99)) inside
                [0:14]:  it.op = OP_LOAD;
                [15:19]: it.op = OP_WEIGHT;
                [20:22]: it.op = OP_UNUSED;
                default: it.op = OP_BIAS;
            endcase
        end
        else
        begin
            span = (tap_limit() > 32) ? 4000 : 12;
            target = taps_done & 1023;
            if (!act_written[target])
            begin
                it.op = OP_LOAD;
                it.idx = 10'(target);
            end
            else if ($urandom_range(0, span) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: it.op = OP_BIAS;
                    1: it.op = OP_UNUSED;
                    default: it.op = OP_LOAD;
                endcase
            end
            else
                it.op = OP_WEIGHT;
        end
        return it;
    endfunction

    task automatic pace_sender();
        int gap;
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = $urandom_range(0, 5);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 20);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic push_item(input layer_item_t it, input bit typed, input mac_res_t typed_res);
        mac_res_t res;
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= {6'd0, it.data, it.idx};
        do @(posedge clk); while (s_tready !== 1'b1);
        if (predict_neuron(it.op, it.idx, it.data, res))
            pending_neurons.push_back(typed ? typed_res : res);
        pace_sender();
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_neurons.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] sel, input logic [10:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= {21'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (sel)
            REG_INPUT_COUNT:  cfg_inputs = value;
            REG_OUTPUT_COUNT: cfg_outputs = value;
            REG_RELU_ENABLE:  cfg_relu = value[0];
            default:
            begin
            end
        endcase
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_neurons.size() == 0)
            begin
                $error("neuron result with nothing expected: value %h index %0d last %0d",
                       m_tdata[31:0], m_tdata[41:32], m_tlast);
                errors++;
            end
            else
            begin
                want = pending_neurons.pop_front();
                if (m_tdata[31:0] !== want.value)
                begin
                    $error("neuron_value expected %h actual %h", want.value, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[41:32] !== want.index)
                begin
                    $error("neuron_index expected %0d actual %0d", want.index, m_tdata[41:32]);
                    errors++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last_neuron expected %0d actual %0d", want.last, m_tlast);
                    errors++;
                end
            end
        end
        rx_tick++;
        if (rx_tick % 64 == 0)
            rx_mode = $urandom_range(0, 3);
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (hold_asked != hold_served)
        begin
            hold_served++;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= rx_tick[0];
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        layer_item_t it;
        int          counted;
        bit          hold_sent;
        bit          useful;

        dir_tab = '{
            '{ROW_CFG,  REG_INPUT_COUNT,  10'd0,   32'd2,          0, '0},
            '{ROW_CFG,  REG_OUTPUT_COUNT, 10'd0,   32'd2,          0, '0},
            '{ROW_CFG,  REG_RELU_ENABLE,  10'd0,   32'd1,          0, '0},
            '{ROW_ITEM, OP_WEIGHT,        10'd0,   32'h7fff_ffff,  0, '0},
            '{ROW_ITEM, OP_UNUSED,        10'h3ff, 32'hffff_ffff,  0, '0},
            '{ROW_ITEM, OP_LOAD,          10'd0,   32'h0001_0000,  0, '0},
            '{ROW_ITEM, OP_LOAD,          10'd1,   32'h0002_0000,  0, '0},
            '{ROW_ITEM, OP_LOAD,          10'h3ff, 32'h8000_0000,  0, '0},
            '{ROW_ITEM, OP_BIAS,          10'd0,   32'h0001_0000,  0, '0},
            '{ROW_ITEM, OP_WEIGHT,        10'd0,   32'h0001_0000,  0, '0},
            '{ROW_ITEM, OP_WEIGHT,        10'd0,   32'h0003_0000,  1, '{32'h0008_0000, 10'd0, 1'b0}},
            '{ROW_ITEM, OP_BIAS,          10'd0,   32'd5,          0, '0},
            '{ROW_ITEM, OP_BIAS,          10'd0,   32'hffff_0000,  0, '0},
            '{ROW_ITEM, OP_WEIGHT,        10'd0,   32'd0,          0, '0},
            '{ROW_ITEM, OP_WEIGHT,        10'd0,   32'd0,          1, '{32'd0, 10'd1, 1'b1}},
            '{ROW_CFG,  REG_RELU_ENABLE,  10'd0,   32'd0,          0, '0},
            '{ROW_ITEM, OP_BIAS,          10'd0,   32'h8000_0000,  0, '0},
            '{ROW_ITEM, OP_WEIGHT,        10'd0,   32'd0,          0, '0},
            '{ROW_ITEM, OP_WEIGHT,        10'd0,   32'd0,          1, '{32'h8000_0000, 10'd0, 1'b0}},
            '{ROW_CFG,  REG_INPUT_COUNT,  10'd0,   32'd0,          0, '0},
            '{ROW_CFG,  REG_OUTPUT_COUNT, 10'd0,   32'd0,          0, '0},
            '{ROW_ITEM, OP_BIAS,          10'd0,   32'h7fff_ffff,  1, '{32'h7fff_ffff, 10'd1, 1'b1}},
            '{ROW_ITEM, OP_BIAS,          10'd0,   32'hffff_ffff,  1, '{32'hffff_ffff, 10'd0, 1'b1}},
            '{ROW_CFG,  REG_INPUT_COUNT,  10'd0,   32'd1,          0, '0},
            '{ROW_CFG,  REG_OUTPUT_COUNT, 10'd0,   32'd2047,       0, '0},
            '{ROW_CFG,  REG_RELU_ENABLE,  10'd0,   32'd1,          0, '0},
            '{ROW_ITEM, OP_LOAD,          10'd0,   32'h7fff_ffff,  0, '0},
            '{ROW_ITEM, OP_BIAS,          10'd0,   32'd0,          0, '0},
            '{ROW_ITEM, OP_WEIGHT,        10'd0,   32'h8000_0000,  0, '0},
            '{ROW_ITEM, OP_BIAS,          10'd0,   32'h7fff_ffff,  0, '0},
            '{ROW_ITEM, OP_WEIGHT,        10'd0,   32'h7fff_ffff,  0, '0}
        };

        phase_tab = '{
            '{11'd1,    11'd5,    1'b1, 150,  1},
            '{11'd3,    11'd4,    1'b0, 150,  0},
            '{11'd0,    11'd1024, 1'b0, 200,  1},
            '{11'd40,   11'd7,    1'b0, 250,  0},
            '{11'd2047, 11'd2047, 1'b1, 200,  0},
            '{11'd5,    11'd0,    1'b1, 100,  0},
            '{11'd2,    11'd1,    1'b1, 80,   0},
            '{11'd7,    11'd3,    1'b0, 80,   0}
        };

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        hold_asked = 0;
        burst_left = 1;
        acc_sum = '0;
        taps_done = 0;
        neuron_no = '0;
        neuron_busy = 1'b0;
        cfg_inputs = 11'd1024;
        cfg_outputs = 11'd1024;
        cfg_relu = 1'b1;
        for (int i = 0; i < 1024; i++)
        begin
            act_mem[i] = '0;
            act_written[i] = 1'b0;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[r])
        begin
            if (dir_tab[r].kind == ROW_CFG)
            begin
                wait_idle();
                cfg_write(dir_tab[r].sel, dir_tab[r].data[10:0]);
            end
            else
            begin
                it.op = dir_tab[r].sel;
                it.idx = dir_tab[r].idx;
                it.data = dir_tab[r].data;
                push_item(it, dir_tab[r].typed, dir_tab[r].want);
            end
        end

        foreach (phase_tab[p])
        begin
            wait_idle();
            cfg_write(REG_INPUT_COUNT, phase_tab[p].inputs);
            cfg_write(REG_OUTPUT_COUNT, phase_tab[p].outputs);
            cfg_write(REG_RELU_ENABLE, {10'd0, phase_tab[p].relu});
            counted = 0;
            hold_sent = 1'b0;
            while (counted < phase_tab[p].items)
            begin
                it = next_layer_item();
                useful = (it.op != OP_UNUSED) && !(it.op == OP_WEIGHT && !neuron_busy);
                if (useful)
                    counted++;
                if (phase_tab[p].hold && !hold_sent && counted == 40)
                begin
                    hold_asked++;
                    hold_sent = 1'b1;
                end
                push_item(it, 1'b0, '0);
            end
        end

        wait_idle();
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/q16dl_pkg.sv
rtl/q16dl_mac.sv
rtl/q16_dense_layer_relu.sv
tb/sv/tb.sv
